[rtl/mrff_pkg.sv]
// ----------------------------------------------------------------------------
// mrff_pkg
// Shared constants, types and helper functions of the request framer and
// fragmenter.
// ----------------------------------------------------------------------------
package mrff_pkg;

	// Default capacity of the request character store.
	localparam int REQUEST_MAX_DEF = 64;

	// Number of fixed bytes ahead of the request characters.
	localparam int PREFIX_LEN = 7;
	// Prefix, ETX and checksum: fixed bytes around the request.
	localparam int FRAME_OVERHEAD = 9;

	localparam logic [7:0] ETX_BYTE = 8'h03;
	// 'R' + '1' + STX + ETX is 0x88, which is 0x08 once masked to seven bits.
	localparam logic [6:0] CHK_BIAS = 7'h08;

	// Link MTU register.
	localparam logic [6:0] MTU_RESET = 7'd23;
	localparam logic [6:0] MTU_MIN_PAYLOAD = 7'd4;
	localparam logic [6:0] MTU_WIDE_LIMIT = 7'd23;
	localparam logic [5:0] PAYLOAD_CAP = 6'd63;

	// Input function codes.
	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_SEND = 1'b1;

	// Kind of result loaded into the output register.
	localparam logic [1:0] KIND_STAT = 2'd0;
	localparam logic [1:0] KIND_HDR = 2'd1;
	localparam logic [1:0] KIND_BODY = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       append;
		logic       start;
		logic       load;
		logic [1:0] kind;
	} mrff_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic send_ok;
		logic last;
	} mrff_sts_t;

	// Fixed frame prefix: '/', '?', '!', SOH, 'R', '1', STX.
	function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h2F;
			3'd1: b = 8'h3F;
			3'd2: b = 8'h21;
			3'd3: b = 8'h01;
			3'd4: b = 8'h52;
			3'd5: b = 8'h31;
			3'd6: b = 8'h02;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Even parity in bit 7 over bits 0 to 6.
	function automatic logic [7:0] even_parity(input logic [7:0] v);
		return {^v[6:0], v[6:0]};
	endfunction

endpackage

[rtl/mrff_ram.sv]
// ----------------------------------------------------------------------------
// mrff_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[rtl/mrff_dp.sv]
// ----------------------------------------------------------------------------
// mrff_dp
// Datapath: request store, checksum, send position, fragment bookkeeping and
// the output register.
// ----------------------------------------------------------------------------
module mrff_dp
	import mrff_pkg::*;
#(
	parameter int REQUEST_MAX = REQUEST_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  mrff_cmd_t  cmd,
	output mrff_sts_t  sts,
	input  logic [7:0] request_char,
	input  logic       cfg_we,
	input  logic [6:0] cfg_data,
	output logic [7:0] out_byte,
	output logic       status,
	output logic       fragment_end,
	output logic       frame_end
);

	localparam int CW = $clog2(REQUEST_MAX + 1);
	localparam int TW = $clog2(REQUEST_MAX + FRAME_OVERHEAD + 1);
	localparam int AW = (REQUEST_MAX > 1) ? $clog2(REQUEST_MAX) : 1;

	logic [CW-1:0] count_q;
	logic [6:0]    sum_q;
	logic [TW-1:0] pos_q;
	logic [TW-1:0] pos_d;
	logic          pending_q;
	logic          started_q;
	logic [6:0]    seq_q;
	logic [6:0]    mtu_q;
	logic [7:0]    header_q;
	logic [5:0]    plen_q;
	logic          more_q;
	logic [5:0]    cnt_q;

	logic [CW-1:0] count_base;
	logic [6:0]    sum_base;
	logic          wr_en;
	logic [TW-1:0] rd_pos;
	logic [7:0]    rd_data;
	logic [TW-1:0] total;
	logic [TW-1:0] remaining;
	logic [6:0]    payload_raw;
	logic [5:0]    payload;
	logic          mtu_ok;
	logic          more;
	logic [5:0]    plen;
	logic [6:0]    seq_next;
	logic [7:0]    header;
	logic [TW-1:0] req_end;
	logic [7:0]    raw_byte;
	logic          body_load;
	logic          last;

	// Append: a partly or fully sent frame is discarded first.
	assign count_base = started_q ? '0 : count_q;
	assign sum_base = started_q ? '0 : sum_q;
	assign wr_en = cmd.append && (count_base < CW'(REQUEST_MAX));

	// Fragment sizing for the send being started.
	assign total = TW'(count_q) + TW'(FRAME_OVERHEAD);
	assign remaining = (pos_q < total) ? (total - pos_q) : '0;
	assign mtu_ok = mtu_q > MTU_MIN_PAYLOAD;
	assign payload_raw = mtu_q - MTU_MIN_PAYLOAD;
	assign payload = (payload_raw > 7'(PAYLOAD_CAP)) ? PAYLOAD_CAP : payload_raw[5:0];
	assign more = remaining > TW'(payload);
	assign plen = more ? payload : remaining[5:0];
	assign seq_next = seq_q + 7'd1;

	// Header byte of the fragment being started.
	always_comb begin
		if (!started_q) begin
			header = more ? 8'h00 : {1'b1, mtu_q > MTU_WIDE_LIMIT, 6'b0};
		end else begin
			header = {~more, seq_next};
		end
	end

	assign sts.send_ok = pending_q && mtu_ok && (remaining != '0);
	assign last = cnt_q == 6'd1;
	assign sts.last = last;
	assign body_load = cmd.load && (cmd.kind == KIND_BODY);

	// Next send position; the store is read one position ahead.
	always_comb begin
		pos_d = pos_q;
		if (cmd.append && started_q) begin
			pos_d = '0;
		end else if (body_load) begin
			pos_d = (last && !more_q) ? '0 : pos_q + TW'(1);
		end
	end

	assign rd_pos = pos_d - TW'(PREFIX_LEN);

	mrff_ram #(
		.WIDTH(8),
		.DEPTH(REQUEST_MAX)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_base[AW-1:0]),
		.wr_data(request_char),
		.rd_addr(rd_pos[AW-1:0]),
		.rd_data(rd_data)
	);

	// Raw frame byte at the current send position.
	assign req_end = TW'(PREFIX_LEN) + TW'(count_q);
	always_comb begin
		if (pos_q < TW'(PREFIX_LEN)) begin
			raw_byte = prefix_byte(pos_q[2:0]);
		end else if (pos_q < req_end) begin
			raw_byte = rd_data;
		end else if (pos_q == req_end) begin
			raw_byte = ETX_BYTE;
		end else begin
			raw_byte = {1'b0, sum_q + CHK_BIAS};
		end
	end

	// Request and send state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
			pos_q <= '0;
			pending_q <= 1'b0;
			started_q <= 1'b0;
			seq_q <= '0;
			mtu_q <= MTU_RESET;
		end else begin
			pos_q <= pos_d;
			if (cfg_we) begin
				mtu_q <= cfg_data;
			end
			if (cmd.append) begin
				started_q <= 1'b0;
				pending_q <= 1'b1;
				if (started_q) begin
					seq_q <= '0;
				end
				if (wr_en) begin
					count_q <= count_base + CW'(1);
					sum_q <= sum_base + request_char[6:0];
				end else begin
					count_q <= count_base;
					sum_q <= sum_base;
				end
			end else if (cmd.start) begin
				if (sts.send_ok) begin
					started_q <= 1'b1;
					seq_q <= started_q ? seq_next : '0;
				end else if (pending_q && mtu_ok) begin
					pending_q <= 1'b0;
				end
			end else if (body_load && last && !more_q) begin
				pending_q <= 1'b0;
			end
		end
	end

	// Fragment registers and byte countdown.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			header_q <= header;
			plen_q <= plen;
			more_q <= more;
		end
		if (cmd.load && (cmd.kind == KIND_HDR)) begin
			cnt_q <= plen_q;
		end else if (body_load) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			case (cmd.kind)
				KIND_HDR: begin
					out_byte <= header_q;
					status <= 1'b0;
					fragment_end <= 1'b0;
					frame_end <= 1'b0;
				end
				KIND_BODY: begin
					out_byte <= even_parity(raw_byte);
					status <= 1'b0;
					fragment_end <= last;
					frame_end <= last && !more_q;
				end
				default: begin
					out_byte <= 8'h00;
					status <= 1'b1;
					fragment_end <= 1'b0;
					frame_end <= 1'b0;
				end
			endcase
		end
	end

endmodule

[rtl/mrff_ctrl.sv]
// ----------------------------------------------------------------------------
// mrff_ctrl
// Controller: accepts items, sequences status, header and payload bytes and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module mrff_ctrl
	import mrff_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      func,
	output logic      out_valid,
	input  logic      out_ready,
	output mrff_cmd_t cmd,
	input  mrff_sts_t sts
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_STAT = 2'd1;
	localparam logic [1:0] ST_HDR = 2'd2;
	localparam logic [1:0] ST_BODY = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       in_acc;
	logic       slot_free;

	assign in_ready = state_q == ST_IDLE;
	assign in_acc = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Commands and next state.
	always_comb begin
		state_d = state_q;
		cmd.append = 1'b0;
		cmd.start = 1'b0;
		cmd.load = 1'b0;
		cmd.kind = KIND_STAT;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (func == FUNC_APPEND) begin
						cmd.append = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d = sts.send_ok ? ST_HDR : ST_STAT;
					end
				end
			end
			ST_STAT: begin
				cmd.kind = KIND_STAT;
				cmd.load = slot_free;
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_HDR: begin
				cmd.kind = KIND_HDR;
				cmd.load = slot_free;
				if (slot_free) begin
					state_d = ST_BODY;
				end
			end
			ST_BODY: begin
				cmd.kind = KIND_BODY;
				cmd.load = slot_free;
				if (slot_free && sts.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/meter_request_framer_fragmenter.sv]
// ----------------------------------------------------------------------------
// meter_request_framer_fragmenter
// Builds a meter read request frame from appended characters and sends it
// in header-led fragments sized by the link MTU.
// ----------------------------------------------------------------------------
// An append item gives no result and leaves the block ready for the next
// item. A send item gives one result per cycle while out_ready is high: a
// lone status item, or a header followed by up to min(link_mtu - 4, 63)
// frame bytes, and the next item is taken only after the last of them is
// loaded. The rate is set by the single output register, which is refilled
// every cycle that it is free; the request store is a RAM with registered
// read that is addressed one position ahead of the byte being formed, so it
// does not slow the rate. The store needs no clearing pass after reset: only
// entries below the character count are read. link_mtu resets to 23 and may
// be written at any time the block is idle.
// ----------------------------------------------------------------------------
module meter_request_framer_fragmenter
	import mrff_pkg::*;
#(
	parameter int REQUEST_MAX = REQUEST_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       func,
	input  logic [7:0] request_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       status,
	output logic       fragment_end,
	output logic       frame_end,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] cfg_data
);

	mrff_cmd_t cmd;
	mrff_sts_t sts;

	// The register write is always taken at once.
	assign cfg_ready = 1'b1;

	mrff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mrff_dp #(
		.REQUEST_MAX(REQUEST_MAX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.request_char(request_char),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.out_byte    (out_byte),
		.status      (status),
		.fragment_end(fragment_end),
		.frame_end   (frame_end)
	);

endmodule

[rtl/mrff_checker.sv]
// ----------------------------------------------------------------------------
// mrff_checker
// Port-level checks of the request framer and fragmenter, bound to the top
// level.
// ----------------------------------------------------------------------------
module mrff_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       func,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       status,
	input logic       fragment_end,
	input logic       frame_end
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status))
		else $error("stalled result changed");

	// A status item carries a zero byte and no end marks.
	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> out_byte == 8'h00 && !fragment_end && !frame_end)
		else $error("malformed status item");

	// The end of the frame is always the end of a fragment.
	a_frame_in_frag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> fragment_end)
		else $error("frame end outside fragment end");

	// Once a send item is taken, no further item is taken in the next cycle.
	a_send_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func |=> !in_ready)
		else $error("item taken during a send");

endmodule

bind meter_request_framer_fragmenter mrff_checker u_mrff_checker (.*);

[dv/meter_request_framer_fragmenter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_request_framer_fragmenter_test
// Self-checking bench for the meter request framer and fragmenter. A built-in
// model of the frame and of the fragment headers predicts every result byte;
// directed tests cover the corner cases and a long output hold-off, and a long
// random run follows, with random idling on both sides and several MTU settings.
// ----------------------------------------------------------------------------
module meter_request_framer_fragmenter_test;
	import mrff_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_ITEMS = 400;
	localparam logic [7:0] HDR_LAST = 8'h80;
	localparam logic [7:0] HDR_WIDE = 8'h40;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       status;
		logic       fragment_end;
		logic       frame_end;
	} frag_result_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       func = FUNC_APPEND;
	logic [7:0] request_char = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       status;
	logic       fragment_end;
	logic       frame_end;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [6:0] cfg_data = MTU_RESET;

	// Model of the framer state and the MTU register.
	logic [7:0] req_store [REQUEST_MAX_DEF];
	int         req_count;
	logic [6:0] req_sum;
	int         tx_pos;
	bit         tx_pending;
	bit         tx_started;
	logic [6:0] frag_seq;
	logic [6:0] mtu_model;

	frag_result_t fragment_due [$];
	int failures = 0;
	int items_done = 0;
	bit steady = 1'b0;
	bit hold_off_req = 1'b0;
	int idle_cycles = 0;

	meter_request_framer_fragmenter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.request_char (request_char),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.status       (status),
		.fragment_end (fragment_end),
		.frame_end    (frame_end),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Frame model -----------------------------------------------------------

	function automatic void clear_request_model();
		req_count = 0;
		req_sum = '0;
		tx_pos = 0;
		tx_pending = 1'b0;
		tx_started = 1'b0;
		frag_seq = '0;
	endfunction

	// Fixed lead-in: '/', '?', '!', SOH, 'R', '1', STX.
	function automatic logic [7:0] lead_in_byte(input int pos);
		logic [7:0] b;
		case (pos)
			0: b = 8'h2F;
			1: b = 8'h3F;
			2: b = 8'h21;
			3: b = 8'h01;
			4: b = 8'h52;
			5: b = 8'h31;
			default: b = 8'h02;
		endcase
		return b;
	endfunction

	// Frame byte at a position, with even parity placed in bit 7.
	function automatic logic [7:0] frame_byte_at(input int pos);
		logic [7:0] raw;
		if (pos < PREFIX_LEN)
			raw = lead_in_byte(pos);
		else if (pos < PREFIX_LEN + req_count)
			raw = req_store[pos - PREFIX_LEN];
		else if (pos == PREFIX_LEN + req_count)
			raw = ETX_BYTE;
		else
			raw = {1'b0, req_sum + CHK_BIAS};
		return {^raw[6:0], raw[6:0]};
	endfunction

	function automatic void owe(input logic [7:0] b, input logic st, input logic fe,
		input logic me);
		frag_result_t r;
		r.out_byte = b;
		r.status = st;
		r.fragment_end = fe;
		r.frame_end = me;
		fragment_due.push_back(r);
	endfunction

	// Works out the results of one accepted item and advances the model.
	function automatic void build_fragment(input logic f, input logic [7:0] ch);
		int total;
		int remaining;
		int payload;
		int plen;
		bit more;
		logic [7:0] header;
		if (f == FUNC_APPEND) begin
			if (tx_started)
				clear_request_model();
			if (req_count < REQUEST_MAX_DEF) begin
				req_store[req_count] = ch;
				req_count++;
				req_sum = req_sum + ch[6:0];
			end
			tx_pending = 1'b1;
			return;
		end
		if (!tx_pending || mtu_model <= MTU_MIN_PAYLOAD) begin
			owe(8'h00, 1'b1, 1'b0, 1'b0);
			return;
		end
		total = req_count + FRAME_OVERHEAD;
		remaining = (tx_pos < total) ? total - tx_pos : 0;
		payload = int'(mtu_model) - 4;
		if (payload > int'(PAYLOAD_CAP))
			payload = int'(PAYLOAD_CAP);
		if (remaining == 0) begin
			tx_pending = 1'b0;
			owe(8'h00, 1'b1, 1'b0, 1'b0);
			return;
		end
		more = remaining > payload;
		plen = more ? payload : remaining;
		if (!tx_started) begin
			tx_started = 1'b1;
			frag_seq = '0;
			header = more ? 8'h00 : (HDR_LAST | ((mtu_model > MTU_WIDE_LIMIT) ? HDR_WIDE : 8'h00));
		end else begin
			frag_seq = frag_seq + 7'd1;
			header = {1'b0, frag_seq} | (more ? 8'h00 : HDR_LAST);
		end
		owe(header, 1'b0, 1'b0, 1'b0);
		for (int i = 0; i < plen; i++)
			owe(frame_byte_at(tx_pos + i), 1'b0, i == plen - 1, (i == plen - 1) && !more);
		if (more) begin
			tx_pos = tx_pos + plen;
		end else begin
			tx_pos = 0;
			tx_pending = 1'b0;
		end
	endfunction

	// Shared stimulus tasks -------------------------------------------------

	// Offers one item, after a random gap unless steady is set, and waits for it to be taken.
	task automatic drive_item(input logic f, input logic [7:0] ch);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		request_char <= ch;
		do @(posedge clk); while (!in_ready);
		// A dropped character changes nothing, so it does not count.
		if (!(f == FUNC_APPEND && req_count >= REQUEST_MAX_DEF && !tx_started))
			items_done++;
		build_fragment(f, ch);
	endtask

	// Stops offering and waits until every predicted result has come.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (fragment_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_link_mtu(input logic [6:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mtu_model = v;
	endtask

	task automatic append_chars(input int n);
		repeat (n) drive_item(FUNC_APPEND, 8'($urandom_range(0, 255)));
	endtask

	// Sends fragments until the whole frame is out.
	task automatic send_frame();
		while (tx_pending && mtu_model > MTU_MIN_PAYLOAD)
			drive_item(FUNC_SEND, 8'($urandom_range(0, 255)));
	endtask

	function automatic logic [6:0] pick_mtu();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 7'($urandom_range(0, 4));
		if (r == 1)
			return 7'd127;
		if (r == 2)
			return 7'd67;
		if (r == 3)
			return 7'($urandom_range(68, 126));
		return 7'($urandom_range(5, 40));
	endfunction

	// Tests -----------------------------------------------------------------

	// A send straight after reset has nothing to send.
	task automatic test_send_when_empty();
		drive_item(FUNC_SEND, 8'h00);
	endtask

	// One short request fits in a single fragment at the reset MTU.
	task automatic test_single_fragment();
		drive_item(FUNC_APPEND, 8'h30);
		send_frame();
		drive_item(FUNC_SEND, 8'hFF);
	endtask

	// Character extremes, a zero character and a frame split over several
	// fragments.
	task automatic test_char_extremes();
		set_link_mtu(7'd8);
		drive_item(FUNC_APPEND, 8'h00);
		drive_item(FUNC_APPEND, 8'hFF);
		drive_item(FUNC_APPEND, 8'h80);
		drive_item(FUNC_APPEND, 8'h7F);
		drive_item(FUNC_APPEND, 8'h55);
		drive_item(FUNC_APPEND, 8'hAA);
		send_frame();
	endtask

	// An append after part of a frame has gone starts a new request.
	task automatic test_append_mid_frame();
		drive_item(FUNC_APPEND, 8'h41);
		drive_item(FUNC_APPEND, 8'h42);
		drive_item(FUNC_SEND, 8'h00);
		drive_item(FUNC_APPEND, 8'h43);
		send_frame();
	endtask

	// MTU settings with no room, the smallest room, the wide header bit and
	// the payload cap.
	task automatic test_mtu_corners();
		drive_item(FUNC_APPEND, 8'h31);
		set_link_mtu(7'd0);
		drive_item(FUNC_SEND, 8'h00);
		set_link_mtu(7'd4);
		drive_item(FUNC_SEND, 8'h00);
		set_link_mtu(7'd5);
		drive_item(FUNC_SEND, 8'h00);
		set_link_mtu(7'd127);
		drive_item(FUNC_SEND, 8'h00);
		drive_item(FUNC_APPEND, 8'h32);
		set_link_mtu(7'd24);
		drive_item(FUNC_SEND, 8'h00);
	endtask

	// The output is held off for a long stretch while requests keep coming,
	// then the sender waits for the backlog to drain.
	task automatic test_output_hold_off();
		set_link_mtu(7'd9);
		steady = 1'b1;
		hold_off_req = 1'b1;
		append_chars(20);
		send_frame();
		append_chars(3);
		send_frame();
		steady = 1'b0;
		wait_idle();
	endtask

	// Mostly well-formed requests with random content, mixed with partial
	// sends, stray sends and random noise, over changing MTU settings.
	task automatic test_random_traffic();
		int n;
		int mode;
		items_done = 0;
		while (items_done < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 8)
				set_link_mtu(pick_mtu());
			steady = ($urandom_range(0, 3) == 0);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 20);
			append_chars(n);
			mode = $urandom_range(0, 9);
			if (mode <= 5) begin
				send_frame();
				if ($urandom_range(0, 3) == 0)
					drive_item(FUNC_SEND, 8'($urandom_range(0, 255)));
			end else if (mode <= 7) begin
				repeat ($urandom_range(1, 3))
					drive_item(FUNC_SEND, 8'($urandom_range(0, 255)));
			end else if (mode == 8) begin
				repeat ($urandom_range(1, 6))
					drive_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end else begin
				drive_item(FUNC_SEND, 8'($urandom_range(0, 255)));
			end
		end
		steady = 1'b0;
		set_link_mtu(MTU_RESET);
		append_chars(4);
		send_frame();
	endtask

	// Output side -----------------------------------------------------------

	// Accepts results with random stalls and an occasional long hold-off.
	initial begin : output_side
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 3);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Each accepted result is compared with the oldest prediction.
	always @(posedge clk) begin : result_check
		frag_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (fragment_due.size() == 0) begin
				$error("result with none predicted: out_byte %02h status %0b", out_byte, status);
				failures++;
			end else begin
				want = fragment_due.pop_front();
				if (out_byte !== want.out_byte) begin
					$error("out_byte: expected %02h, got %02h", want.out_byte, out_byte);
					failures++;
				end
				if (status !== want.status) begin
					$error("status: expected %0b, got %0b", want.status, status);
					failures++;
				end
				if (fragment_end !== want.fragment_end) begin
					$error("fragment_end: expected %0b, got %0b", want.fragment_end, fragment_end);
					failures++;
				end
				if (frame_end !== want.frame_end) begin
					$error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
					failures++;
				end
			end
		end
	end

	// Ends the run when nothing has been accepted for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$error("no item accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Test sequence ---------------------------------------------------------

	initial begin
		clear_request_model();
		mtu_model = MTU_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_send_when_empty();
		test_single_fragment();
		test_char_extremes();
		test_append_mid_frame();
		test_mtu_corners();
		test_output_hold_off();
		test_random_traffic();
		wait_idle();
		if (fragment_due.size() != 0) begin
			$error("%0d predicted results never arrived", fragment_due.size());
			failures++;
		end
		if (failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
